FILE: hw/rtl/alfp_pkg.sv
// ----------------------------------------------------------------------------
// Absolute loader frame parser package
// Parse phases, header constants and error codes shared by the parser RTL.
// ----------------------------------------------------------------------------
package alfp_pkg;

  // Parse phases.
  localparam logic [2:0] PH_HUNT   = 3'd0;
  localparam logic [2:0] PH_CNT_LO = 3'd1;
  localparam logic [2:0] PH_CNT_HI = 3'd2;
  localparam logic [2:0] PH_ADR_LO = 3'd3;
  localparam logic [2:0] PH_ADR_HI = 3'd4;
  localparam logic [2:0] PH_DATA   = 3'd5;
  localparam logic [2:0] PH_CHECK  = 3'd6;

  // Header and block count constants.
  localparam logic [15:0] HDR_MATCH = 16'h0100;
  localparam logic [15:0] HDR_IDLE  = 16'hFFFF;
  localparam logic [15:0] CNT_FINAL = 16'd6;
  localparam logic [7:0]  HDR_SUM   = 8'h01;

  // Line error codes at the input.
  localparam logic [2:0] LE_NONE   = 3'd0;
  localparam logic [2:0] LE_PARITY = 3'd4;

  // Reported error codes.
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_CHECKSUM = 3'd1;
  localparam logic [2:0] ERR_PARITY   = 3'd5;
  localparam logic [2:0] ERR_BLOCK    = 3'd6;

  // One result as it leaves the parser.
  typedef struct packed {
    logic        mem_write;
    logic [31:0] mem_address;
    logic [7:0]  mem_data;
    logic        finished;
    logic [15:0] entry_address;
    logic [2:0]  error_code;
  } result_t;

endpackage

FILE: hw/rtl/absolute_loader_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// Absolute loader frame parser
// Parses absolute-loader blocks from a byte stream into memory write requests.
// ----------------------------------------------------------------------------
// Each received byte request yields exactly one result request, in the cycle after
// it is accepted. The parser takes one byte per clock: its state update is a
// single pass of logic, and a result register sits between the parse state
// and the output, so s_tready only drops while that register holds a result
// that the sink has not taken. A result carries a memory write for every data
// byte; otherwise it reports the status (finished with the entry address, or
// the latched error code). Once finished or in error, the parser ignores its
// input until rst and answers every byte with the latched status.
module absolute_loader_frame_parser_unit (
  input  logic        clk,
  input  logic        rst,
  // Configuration: base_address.
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  // Byte input.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] rx_byte, [10:8] line_error, rest zero
  // Result output.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [31:0] mem_address, [39:32] mem_data,
                                 // [40] finished, [56:41] entry_address,
                                 // [59:57] error_code, rest zero
  output logic [0:0]  m_tuser    // [0] mem_write
);

  logic [31:0] base_address;

  logic [2:0]  phase,         phase_next;
  logic [15:0] header_window, header_window_next;
  logic [7:0]  running_sum,   running_sum_next;
  logic [15:0] block_count,   block_count_next;
  logic [7:0]  bytes_left,    bytes_left_next;
  logic [31:0] load_pointer,  load_pointer_next;
  logic        done_flag,     done_flag_next;
  logic [2:0]  error_latch,   error_latch_next;

  alfp_pkg::result_t result, result_next;

  logic        accept;
  logic [7:0]  rx_byte;
  logic [2:0]  line_error;
  logic [15:0] window_shift;
  logic [15:0] addr_field;
  logic [7:0]  sum_add;
  logic        data_out;

  assign rx_byte    = s_tdata[7:0];
  assign line_error = s_tdata[10:8];
  assign s_tready   = !m_tvalid || m_tready;
  assign accept     = s_tvalid && s_tready;

  assign window_shift = {header_window[7:0], rx_byte};
  assign addr_field   = {rx_byte, load_pointer[7:0]};
  assign sum_add      = running_sum + rx_byte;

  always_comb begin
    phase_next         = phase;
    header_window_next = header_window;
    running_sum_next   = running_sum;
    block_count_next   = block_count;
    bytes_left_next    = bytes_left;
    load_pointer_next  = load_pointer;
    done_flag_next     = done_flag;
    error_latch_next   = error_latch;
    data_out           = 1'b0;

    if (!done_flag && error_latch == alfp_pkg::ERR_NONE) begin
      if (line_error != alfp_pkg::LE_NONE) begin
        // Line errors map one up; undefined codes saturate to parity.
        error_latch_next = (line_error >= alfp_pkg::LE_PARITY) ?
                           alfp_pkg::ERR_PARITY : line_error + 3'd1;
      end else begin
        case (phase)
          alfp_pkg::PH_HUNT: begin
            header_window_next = window_shift;
            if (window_shift == alfp_pkg::HDR_MATCH) begin
              header_window_next = alfp_pkg::HDR_IDLE;
              running_sum_next   = alfp_pkg::HDR_SUM;
              phase_next         = alfp_pkg::PH_CNT_LO;
            end
          end
          alfp_pkg::PH_CNT_LO: begin
            running_sum_next = sum_add;
            block_count_next = {8'd0, rx_byte};
            phase_next       = alfp_pkg::PH_CNT_HI;
          end
          alfp_pkg::PH_CNT_HI: begin
            running_sum_next = sum_add;
            block_count_next = {rx_byte, block_count[7:0]};
            phase_next       = alfp_pkg::PH_ADR_LO;
          end
          alfp_pkg::PH_ADR_LO: begin
            running_sum_next = sum_add;
            load_pointer_next = {24'd0, rx_byte};
            phase_next        = alfp_pkg::PH_ADR_HI;
          end
          alfp_pkg::PH_ADR_HI: begin
            running_sum_next = sum_add;
            if (block_count[15:8] != 8'd0 || block_count < alfp_pkg::CNT_FINAL) begin
              error_latch_next = alfp_pkg::ERR_BLOCK;
            end else if (block_count == alfp_pkg::CNT_FINAL) begin
              load_pointer_next = {16'd0, addr_field};
              done_flag_next    = 1'b1;
            end else begin
              load_pointer_next = base_address + {16'd0, addr_field};
              bytes_left_next   = block_count[7:0] - alfp_pkg::CNT_FINAL[7:0];
              phase_next        = alfp_pkg::PH_DATA;
            end
          end
          alfp_pkg::PH_DATA: begin
            running_sum_next  = sum_add;
            data_out          = 1'b1;
            load_pointer_next = load_pointer + 32'd1;
            bytes_left_next   = bytes_left - 8'd1;
            if (bytes_left == 8'd1) begin
              phase_next = alfp_pkg::PH_CHECK;
            end
          end
          alfp_pkg::PH_CHECK: begin
            running_sum_next = sum_add;
            if (sum_add != 8'd0) begin
              error_latch_next = alfp_pkg::ERR_CHECKSUM;
            end else begin
              header_window_next = alfp_pkg::HDR_IDLE;
              phase_next         = alfp_pkg::PH_HUNT;
            end
          end
          default: begin
            header_window_next = alfp_pkg::HDR_IDLE;
            phase_next         = alfp_pkg::PH_HUNT;
          end
        endcase
      end
    end

    // Data bytes give a write request; everything else reports the status
    // as it stands after this byte.
    if (data_out) begin
      result_next.mem_write     = 1'b1;
      result_next.mem_address   = load_pointer;
      result_next.mem_data      = rx_byte;
      result_next.finished      = 1'b0;
      result_next.entry_address = 16'd0;
      result_next.error_code    = alfp_pkg::ERR_NONE;
    end else begin
      result_next.mem_write     = 1'b0;
      result_next.mem_address   = 32'd0;
      result_next.mem_data      = 8'd0;
      result_next.finished      = done_flag_next;
      result_next.entry_address = done_flag_next ? load_pointer_next[15:0] : 16'd0;
      result_next.error_code    = error_latch_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address  <= 32'd0;
      phase         <= alfp_pkg::PH_HUNT;
      header_window <= alfp_pkg::HDR_IDLE;
      running_sum   <= 8'd0;
      block_count   <= 16'd0;
      bytes_left    <= 8'd0;
      load_pointer  <= 32'd0;
      done_flag     <= 1'b0;
      error_latch   <= alfp_pkg::ERR_NONE;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        base_address <= cfg_wr_data;
      end
      if (accept) begin
        phase         <= phase_next;
        header_window <= header_window_next;
        running_sum   <= running_sum_next;
        block_count   <= block_count_next;
        bytes_left    <= bytes_left_next;
        load_pointer  <= load_pointer_next;
        done_flag     <= done_flag_next;
        error_latch   <= error_latch_next;
      end
      m_tvalid <= accept || (m_tvalid && !m_tready);
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  assign m_tdata = {4'd0, result.error_code, result.entry_address, result.finished,
                    result.mem_data, result.mem_address};
  assign m_tuser = result.mem_write;

endmodule

FILE: tb/sv/absolute_loader_frame_parser_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Absolute loader frame parser unit test
// Feeds loader blocks, stray bytes and one final block or fault through the
// byte stream, predicts every result request from a model of the parse state,
// and checks each result field by field under random stalls on both sides.
// ----------------------------------------------------------------------------
module absolute_loader_frame_parser_unit_test;

  localparam int unsigned   ITEM_GOAL   = 1100;
  localparam int unsigned   CYCLE_LIMIT = 400000;
  localparam int unsigned   HOLD_CYCLES = 60;
  localparam logic [15:0]   CNT_LIMIT   = 16'd256;
  localparam logic [7:0]    HDR_FIRST   = alfp_pkg::HDR_MATCH[15:8];
  localparam logic [7:0]    HDR_SECOND  = alfp_pkg::HDR_MATCH[7:0];
  localparam logic [15:0]   SINK_PATTERN = 16'b1011_0111_0010_1111;

  // Terminating events; only one can happen per run, since reset is not repeated.
  typedef enum int unsigned {
    END_FINAL_BLOCK,
    END_CHECKSUM,
    END_BAD_COUNT,
    END_LINE_ERROR
  } end_kind_t;

  class load_scoreboard;
    logic [31:0] base_addr;
    logic [2:0]  phase;
    logic [15:0] hdr_window;
    logic [7:0]  blk_sum;
    logic [15:0] blk_count;
    logic [7:0]  left;
    logic [31:0] ptr;
    logic        done;
    logic [2:0]  err_latch;
    alfp_pkg::result_t expected_results[$];
    int unsigned errors;

    function new();
      base_addr  = '0;
      phase      = alfp_pkg::PH_HUNT;
      hdr_window = alfp_pkg::HDR_IDLE;
      blk_sum    = '0;
      blk_count  = '0;
      left       = '0;
      ptr        = '0;
      done       = 1'b0;
      err_latch  = alfp_pkg::ERR_NONE;
      errors     = 0;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    // Advances the parse state by one accepted byte and queues its result.
    function void note_byte(logic [7:0] b, logic [2:0] le);
      alfp_pkg::result_t r;
      logic [15:0]       addr16;
      r = '0;
      if (done || err_latch != alfp_pkg::ERR_NONE) begin
        // Stopped: the byte is ignored.
      end else if (le != alfp_pkg::LE_NONE) begin
        err_latch = (le >= alfp_pkg::LE_PARITY) ? alfp_pkg::ERR_PARITY : le + 3'd1;
      end else begin
        case (phase)
          alfp_pkg::PH_HUNT: begin
            hdr_window = {hdr_window[7:0], b};
            if (hdr_window == alfp_pkg::HDR_MATCH) begin
              hdr_window = alfp_pkg::HDR_IDLE;
              blk_sum    = alfp_pkg::HDR_SUM;
              phase      = alfp_pkg::PH_CNT_LO;
            end
          end
          alfp_pkg::PH_CNT_LO: begin
            blk_sum   = blk_sum + b;
            blk_count = {8'd0, b};
            phase     = alfp_pkg::PH_CNT_HI;
          end
          alfp_pkg::PH_CNT_HI: begin
            blk_sum         = blk_sum + b;
            blk_count[15:8] = b;
            phase           = alfp_pkg::PH_ADR_LO;
          end
          alfp_pkg::PH_ADR_LO: begin
            blk_sum = blk_sum + b;
            ptr     = {24'd0, b};
            phase   = alfp_pkg::PH_ADR_HI;
          end
          alfp_pkg::PH_ADR_HI: begin
            blk_sum = blk_sum + b;
            addr16  = {b, ptr[7:0]};
            if (blk_count >= CNT_LIMIT || blk_count < alfp_pkg::CNT_FINAL) begin
              err_latch = alfp_pkg::ERR_BLOCK;
            end else if (blk_count == alfp_pkg::CNT_FINAL) begin
              ptr  = {16'd0, addr16};
              done = 1'b1;
            end else begin
              ptr   = base_addr + {16'd0, addr16};
              left  = blk_count[7:0] - alfp_pkg::CNT_FINAL[7:0];
              phase = alfp_pkg::PH_DATA;
            end
          end
          alfp_pkg::PH_DATA: begin
            blk_sum       = blk_sum + b;
            r.mem_write   = 1'b1;
            r.mem_address = ptr;
            r.mem_data    = b;
            ptr           = ptr + 32'd1;
            left          = left - 8'd1;
            if (left == 8'd0) phase = alfp_pkg::PH_CHECK;
          end
          alfp_pkg::PH_CHECK: begin
            blk_sum = blk_sum + b;
            if (blk_sum != 8'd0) begin
              err_latch = alfp_pkg::ERR_CHECKSUM;
            end else begin
              hdr_window = alfp_pkg::HDR_IDLE;
              phase      = alfp_pkg::PH_HUNT;
            end
          end
          default: begin
            phase      = alfp_pkg::PH_HUNT;
            hdr_window = alfp_pkg::HDR_IDLE;
          end
        endcase
      end
      if (!r.mem_write) begin
        r.finished      = done;
        r.entry_address = done ? ptr[15:0] : 16'd0;
        r.error_code    = err_latch;
      end
      expected_results.push_back(r);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic mw, logic [63:0] d);
      alfp_pkg::result_t want;
      if (expected_results.size() == 0) begin
        $error("result request arrived with no byte waiting for it");
        errors++;
        return;
      end
      want = expected_results.pop_front();
      compare("mem_write", 32'(want.mem_write), 32'(mw));
      compare("mem_address", want.mem_address, d[31:0]);
      compare("mem_data", 32'(want.mem_data), 32'(d[39:32]));
      compare("finished", 32'(want.finished), 32'(d[40]));
      compare("entry_address", 32'(want.entry_address), 32'(d[56:41]));
      compare("error_code", 32'(want.error_code), 32'(d[59:57]));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;
  logic [0:0]  m_tuser;

  load_scoreboard board = new();
  int unsigned    bytes_sent;
  int unsigned    results_seen;
  int unsigned    burst_left;
  int unsigned    cycles;

  absolute_loader_frame_parser_unit dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("** absolute_loader_frame_parser_unit: FAILED **");
    $finish;
  end

  // Sink: switches between always ready, a fixed stall pattern and coin flips,
  // with two long hold-offs so that the parser backs up into its input.
  initial begin : sink
    int unsigned mode;
    int unsigned mode_left;
    int unsigned tick;
    int unsigned hold_left;
    int unsigned holds_done;
    m_tready   = 1'b0;
    hold_left  = 0;
    holds_done = 0;
    mode_left  = 0;
    mode       = 0;
    tick       = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_left == 0 && ((holds_done == 0 && results_seen >= 200) ||
                             (holds_done == 1 && results_seen >= 700))) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left != 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= SINK_PATTERN[tick[3:0]];
          default: m_tready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      board.check_result(m_tuser[0], m_tdata);
      results_seen++;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic [2:0] le);
    @(negedge clk);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {5'd0, le, b};
    do @(posedge clk); while (!s_tready);
    board.note_byte(b, le);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_base(input logic [31:0] value);
    wait_drained();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    board.base_addr = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Noise between blocks; a header pair is never formed by accident.
  task automatic send_strays(input int unsigned n);
    logic [7:0] prev;
    logic [7:0] b;
    prev = 8'hFF;
    repeat (n) begin
      b = 8'($urandom);
      if (prev == HDR_FIRST && b == HDR_SECOND) b = 8'hFF;
      send_byte(b, alfp_pkg::LE_NONE);
      prev = b;
    end
  endtask

  // A whole block with a correct checksum unless skewed. With a line error
  // given, the block is cut short at a random byte that carries the error.
  task automatic send_block(input logic [15:0] count, input logic [15:0] load_addr,
                            input logic [7:0] sum_skew, input logic [2:0] fault_le);
    logic [7:0]  frame[$];
    logic [7:0]  sum;
    int unsigned payload;
    int unsigned cut;
    payload = (count > alfp_pkg::CNT_FINAL && count < CNT_LIMIT) ?
              32'(count - alfp_pkg::CNT_FINAL) : 0;
    frame = {HDR_FIRST, HDR_SECOND, count[7:0], count[15:8],
             load_addr[7:0], load_addr[15:8]};
    repeat (payload) frame.push_back(8'($urandom));
    if (payload != 0) begin
      sum = 8'd0;
      foreach (frame[i]) sum = sum + frame[i];
      frame.push_back(8'd0 - sum + sum_skew);
    end
    cut = (fault_le != alfp_pkg::LE_NONE) ? $urandom_range(0, frame.size() - 1)
                                          : frame.size();
    for (int i = 0; i < frame.size() && i <= cut; i++)
      send_byte(frame[i], (i == cut) ? fault_le : alfp_pkg::LE_NONE);
  endtask

  function automatic logic [31:0] pick_base();
    case ($urandom_range(0, 3))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom;
      default: return {16'hFFFF, 16'($urandom)};
    endcase
  endfunction

  function automatic logic [15:0] pick_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 88) return 16'($urandom_range(7, 24));
    if (r < 97) return 16'($urandom_range(25, 254));
    return CNT_LIMIT - 16'd1;
  endfunction

  initial begin : stimulus
    end_kind_t   ending;
    logic [15:0] bad_count;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    bytes_sent   = 0;
    results_seen = 0;
    burst_left   = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: stray bytes 0x00 and 0xFF, a stray 0x01 right before the header,
    // store address wrap past the top of memory.
    write_base(32'hFFFF_FFFF);
    send_byte(8'h00, alfp_pkg::LE_NONE);
    send_byte(8'hFF, alfp_pkg::LE_NONE);
    send_byte(HDR_FIRST, alfp_pkg::LE_NONE);
    send_block(16'd7, 16'hFFFF, 8'd0, alfp_pkg::LE_NONE);
    write_base(32'd0);
    send_block(16'd8, 16'h0000, 8'd0, alfp_pkg::LE_NONE);
    write_base($urandom);

    while (bytes_sent < ITEM_GOAL) begin
      case ($urandom_range(0, 49))
        0, 1: write_base(pick_base());
        2:    wait_drained();
        default: begin
          if ($urandom_range(0, 3) == 0) send_strays($urandom_range(1, 5));
          send_block(pick_count(), 16'($urandom), 8'd0, alfp_pkg::LE_NONE);
        end
      endcase
    end

    ending = end_kind_t'($urandom_range(0, 3));
    case (ending)
      END_FINAL_BLOCK: send_block(alfp_pkg::CNT_FINAL, 16'($urandom), 8'd0,
                                  alfp_pkg::LE_NONE);
      END_CHECKSUM:    send_block(pick_count(), 16'($urandom),
                                  8'($urandom_range(1, 255)), alfp_pkg::LE_NONE);
      END_BAD_COUNT: begin
        bad_count = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 5))
                                                : 16'($urandom_range(256, 65535));
        send_block(bad_count, 16'($urandom), 8'd0, alfp_pkg::LE_NONE);
      end
      default:         send_block(pick_count(), 16'($urandom), 8'd0,
                                  3'($urandom_range(1, 7)));
    endcase

    // Once stopped, every byte and line error code must echo the latched status.
    repeat (40) send_byte(8'($urandom), 3'($urandom_range(0, 7)));

    wait_drained();
    repeat (8) @(posedge clk);
    if (board.errors == 0) begin
      $display("** absolute_loader_frame_parser_unit: PASSED **");
    end else begin
      $display("** absolute_loader_frame_parser_unit: FAILED **");
    end
    $finish;
  end

endmodule
